/* rtl/core/sobel_pkg.sv */
// shared constants and types for the sobel edge stream block
package sobel_pkg;

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 4096;

  localparam int unsigned PixW   = 8;
  localparam int unsigned WidthW = 11;
  localparam int unsigned HeightW = 13;
  localparam int unsigned RowW   = 12;
  localparam int unsigned ColW   = 10;
  localparam int unsigned GradW  = 11;
  localparam int unsigned MagW   = 15;
  localparam int unsigned SqW    = 29;
  localparam int unsigned RootSteps = 15;

  localparam logic CfgIdxWidth  = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;

  typedef struct packed {
    logic fetch;
    logic load;
    logic step;
    logic finish;
  } sobel_cmd_t;

  typedef struct packed {
    logic emit;
    logic root_done;
  } sobel_sts_t;

endpackage

/* rtl/core/sobel_ctrl.sv */
// controller state machine: pixel intake, root iteration, result handoff
module sobel_ctrl
  import sobel_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  output logic       in_ready_o,
  input  logic       out_free_i,
  input  sobel_sts_t sts_i,
  output sobel_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StRoot = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_fire_i) begin
          cmd_o.fetch = 1'b1;
          state_d = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load = 1'b1;
        state_d = StRoot;
      end
      StRoot: begin
        if (!sts_i.emit) begin
          state_d = StIdle;
        end else if (sts_i.root_done) begin
          state_d = StOut;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      StOut: begin
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  a_fetch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fetch |-> state_q == StIdle) else $error("fetch outside idle");
  a_load_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fetch |=> cmd_o.load) else $error("load does not follow fetch");
  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == StIdle) else $error("finish not back to idle");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.fetch, cmd_o.load, cmd_o.step, cmd_o.finish}))
    else $error("commands overlap");

endmodule

/* rtl/core/sobel_dp.sv */
// datapath: line stores, window, counters, gradients and bit-serial root
module sobel_dp
  import sobel_pkg::*;
#(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sobel_cmd_t          cmd_i,
  output sobel_sts_t          sts_o,
  input  logic [PixW-1:0]     pixel_i,
  input  logic                frame_start_i,
  input  logic [WidthW-1:0]   width_i,
  input  logic [HeightW-1:0]  height_i,
  output logic [RowW-1:0]     center_row_o,
  output logic [ColW-1:0]     center_col_o,
  output logic [GradW-1:0]    grad_h_o,
  output logic [GradW-1:0]    grad_v_o,
  output logic [MagW-1:0]     mag_o,
  output logic                last_o
);

  localparam int unsigned AddrW = $clog2(MaxWidth);
  localparam int unsigned CW = $clog2(MaxWidth + 1);
  localparam int unsigned RW = $clog2(MaxHeight + 1);
  localparam int unsigned DW = (CW > RW) ? CW : RW;
  localparam int unsigned CntW = $clog2(RootSteps + 2);

  logic [PixW-1:0] mem_a [MaxWidth];
  logic [PixW-1:0] mem_b [MaxWidth];

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [PixW-1:0] win_q [3][3];
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [CW-1:0] c_fetch;
  logic [CW-1:0] c_cur;
  logic [RW-1:0] r_cur;
  logic [PixW-1:0] rd_a_q, rd_b_q, pix_q;
  logic fs_q;
  logic [PixW-1:0] top, mid;
  logic c_in;
  logic [AddrW-1:0] addr, addr_fetch;
  logic emit_q;
  logic [RowW-1:0] row_out_q;
  logic [ColW-1:0] col_out_q;
  logic last_q;
  logic signed [GradW-1:0] gh_q, gv_q;
  logic [MagW+1:0] rem_q;
  logic [MagW-1:0] res_q;
  logic [CntW-1:0] cnt_q;
  logic [2*MagW-1:0] x_q;
  logic signed [2*GradW-1:0] ghsq, gvsq;
  logic [SqW-1:0] sq;
  logic [MagW+1:0] nrem, trial;
  logic signed [GradW+1:0] nh, nv;

  // clamp registers to legal dimensions
  always_comb begin
    if ({{(DW-WidthW){1'b0}}, width_i} < DW'(3)) w_eff = CW'(3);
    else if (DW'(width_i) > DW'(MaxWidth)) w_eff = CW'(MaxWidth);
    else w_eff = CW'(width_i);
    if (DW'(height_i) < DW'(3)) h_eff = RW'(3);
    else if (DW'(height_i) > DW'(MaxHeight)) h_eff = RW'(MaxHeight);
    else h_eff = RW'(height_i);
  end

  assign c_fetch    = frame_start_i ? '0 : col_q;
  assign addr_fetch = AddrW'(c_fetch);
  assign c_cur = fs_q ? '0 : col_q;
  assign r_cur = fs_q ? '0 : row_q;
  assign c_in  = c_cur < CW'(MaxWidth);
  assign addr  = AddrW'(c_cur);
  assign top   = c_in ? rd_b_q : '0;
  assign mid   = c_in ? rd_a_q : '0;

  // line stores read at intake, written back in the following cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      rd_a_q <= mem_a[addr_fetch];
      rd_b_q <= mem_b[addr_fetch];
      pix_q  <= pixel_i;
      fs_q   <= frame_start_i;
    end
    if (cmd_i.load && c_in) begin
      mem_b[addr] <= mid;
      mem_a[addr] <= pix_q;
    end
  end

  // gradients of the window after shift
  always_comb begin
    nh = $signed({4'b0, win_q[0][1]}) + $signed({3'b0, win_q[1][1], 1'b0})
       + $signed({4'b0, win_q[2][1]}) - $signed({4'b0, top})
       - $signed({3'b0, mid, 1'b0}) - $signed({4'b0, pix_q});
    nv = $signed({4'b0, win_q[0][1]}) + $signed({3'b0, win_q[0][2], 1'b0})
       + $signed({4'b0, top}) - $signed({4'b0, win_q[2][1]})
       - $signed({3'b0, win_q[2][2], 1'b0}) - $signed({4'b0, pix_q});
  end

  assign ghsq = gh_q * gh_q;
  assign gvsq = gv_q * gv_q;
  assign sq   = SqW'(ghsq) + SqW'(gvsq);

  assign nrem  = {rem_q[MagW-1:0], x_q[2*MagW-1 -: 2]};
  assign trial = {res_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      emit_q <= 1'b0;
      cnt_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (cmd_i.load) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= top;
      win_q[1][2] <= mid;
      win_q[2][2] <= pix_q;
      emit_q <= (r_cur >= RW'(2)) && (r_cur < h_eff) && (c_cur >= CW'(2)) && (c_cur < w_eff);
      cnt_q  <= '0;
      if (CW'(c_cur + 1'b1) >= w_eff || c_cur == '1) begin
        col_q <= '0;
        row_q <= (RW'(r_cur + 1'b1) >= h_eff || r_cur == '1) ? '0 : RW'(r_cur + 1'b1);
      end else begin
        col_q <= CW'(c_cur + 1'b1);
        row_q <= r_cur;
      end
    end else if (cmd_i.step) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      gh_q <= GradW'(nh);
      gv_q <= GradW'(nv);
      row_out_q <= RowW'(r_cur - 1'b1);
      col_out_q <= ColW'(c_cur - 1'b1);
      last_q <= (r_cur == h_eff - 1'b1) && (c_cur == w_eff - 1'b1);
    end else if (cmd_i.step) begin
      if (cnt_q == '0) begin
        // first step only latches the squared sum, scaled by 256
        x_q   <= {sq[2*MagW-9:0], 8'b0};
        rem_q <= '0;
        res_q <= '0;
      end else begin
        if (nrem >= trial) begin
          rem_q <= nrem - trial;
          res_q <= {res_q[MagW-2:0], 1'b1};
        end else begin
          rem_q <= nrem;
          res_q <= {res_q[MagW-2:0], 1'b0};
        end
        x_q <= {x_q[2*MagW-3:0], 2'b00};
      end
    end
  end

  assign sts_o.emit      = emit_q;
  assign sts_o.root_done = cnt_q == CntW'(RootSteps + 1);
  assign center_row_o = row_out_q;
  assign center_col_o = col_out_q;
  assign grad_h_o     = gh_q;
  assign grad_v_o     = gv_q;
  assign mag_o        = res_q;
  assign last_o       = last_q;

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= CW'(MaxWidth)) else $error("column counter out of range");
  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> cnt_q <= CntW'(RootSteps)) else $error("root stepped too far");
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> cnt_q == '0) else $error("root count not cleared");

endmodule

/* rtl/core/sobel_edge_stream.sv */
// top level of the streaming 3x3 sobel edge detector
// pixels enter on s_axis in raster order; tuser marks row 0 column 0
// of a new frame, but counters also wrap by themselves at frame end
// results leave on m_axis for interior pixels only, with tlast on the
// final interior pixel of a frame; border pixels give no item
// cfg port writes image_width (index 0) and image_height (index 1);
// write it only while the block is idle
// the accept cycle also reads both line stores; the load state that follows
// updates window, line stores and gradients; a border pixel then passes
// through the root state, which sees no item and returns to idle
// an interior pixel goes through the bit-serial square root (a latch
// step, 15 bit steps and a done check) and then into the output register;
// the next pixel is taken only after that, one pixel at a time
// a stalled sink holds the result in the output register; the next
// interior result then waits for it, which stops intake
// reset clears counters and window and sets width 640, height 480;
// line stores are not cleared and need no sweep
module sobel_edge_stream
  import sobel_pkg::*;
#(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // pixel
  input  logic        s_axis_tuser,  // frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // center_row[11:0], center_col[21:12], grad_horizontal[32:22],
  // grad_vertical[43:33], magnitude[58:44], zero fill
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [12:0] cfg_data_i
);

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  sobel_cmd_t cmd;
  sobel_sts_t sts;
  logic [RowW-1:0] row;
  logic [ColW-1:0] col;
  logic [GradW-1:0] gh, gv;
  logic [MagW-1:0] mag;
  logic last, out_v_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthW'(640);
      height_q <= HeightW'(480);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgIdxWidth:  width_q  <= cfg_data_i[WidthW-1:0];
        CfgIdxHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sobel_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i  (s_axis_tvalid && s_axis_tready),
    .in_ready_o (s_axis_tready),
    .out_free_i (!out_v_q || m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sobel_dp #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd), .sts_o (sts),
    .pixel_i (s_axis_tdata), .frame_start_i (s_axis_tuser),
    .width_i (width_q), .height_i (height_q),
    .center_row_o (row), .center_col_o (col),
    .grad_h_o (gh), .grad_v_o (gv), .mag_o (mag), .last_o (last)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd.finish) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.finish) begin
      m_axis_tdata <= {5'b0, mag, gv, gh, col, row};
      m_axis_tlast <= last;
    end
  end

  assign m_axis_tvalid = out_v_q;

endmodule

/* bench/tb_sobel_edge_stream.sv */
// self-checking testbench for the streaming 3x3 sobel edge detector
`timescale 1ns / 100ps

module tb_sobel_edge_stream;
  import sobel_pkg::*;

  typedef struct packed {
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [GradW-1:0] gh;
    logic [GradW-1:0] gv;
    logic [MagW-1:0]  mag;
    logic             last;
  } edge_res_t;

  class sobel_tracker;
    logic [WidthW-1:0]  width_reg;
    logic [HeightW-1:0] height_reg;
    logic [7:0] line_above [DefMaxWidth];
    logic [7:0] line_two_above [DefMaxWidth];
    logic [7:0] win [3][3];
    int unsigned row_pos;
    int unsigned col_pos;
    edge_res_t edge_q[$];
    int mismatches;

    function new();
      width_reg = WidthW'(640);
      height_reg = HeightW'(480);
      foreach (line_above[i]) begin
        line_above[i] = '0;
        line_two_above[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      row_pos = 0;
      col_pos = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic idx, logic [12:0] data);
      if (idx == CfgIdxWidth) width_reg = data[WidthW-1:0];
      else height_reg = data;
    endfunction

    function int unsigned dim_used(int unsigned v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function void take_pixel(logic [7:0] px, logic fs);
      int unsigned w, h, r, c;
      logic [7:0] top, mid;
      int gh, gv;
      longint unsigned sq, cand;
      longint unsigned root;
      edge_res_t e;
      w = dim_used(width_reg, DefMaxWidth);
      h = dim_used(height_reg, DefMaxHeight);
      if (fs) begin
        row_pos = 0;
        col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      top = '0;
      mid = '0;
      if (c < DefMaxWidth) begin
        top = line_two_above[c];
        mid = line_above[c];
        line_two_above[c] = mid;
        line_above[c] = px;
      end
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = px;
      if (r >= 2 && r < h && c >= 2 && c < w) begin
        gh = int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0])
           - int'(win[0][2]) - 2 * int'(win[1][2]) - int'(win[2][2]);
        gv = int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2])
           - int'(win[2][0]) - 2 * int'(win[2][1]) - int'(win[2][2]);
        sq = longint'(gh * gh + gv * gv) * 256;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
          cand = root | (64'd1 << b);
          if (cand * cand <= sq) root = cand;
        end
        e.row = RowW'(r - 1);
        e.col = ColW'(c - 1);
        e.gh = GradW'(gh);
        e.gv = GradW'(gv);
        e.mag = MagW'(root);
        e.last = (r == h - 1 && c == w - 1);
        edge_q.push_back(e);
      end
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_result(logic [63:0] data, logic last);
      edge_res_t got, exp_r;
      got.row = data[11:0];
      got.col = data[21:12];
      got.gh = data[32:22];
      got.gv = data[43:33];
      got.mag = data[58:44];
      got.last = last;
      if (edge_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result row %0d col %0d", got.row, got.col);
        return;
      end
      exp_r = edge_q.pop_front();
      if (got != exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch exp r%0d c%0d gh%0d gv%0d m%0d l%0d",
                    " got r%0d c%0d gh%0d gv%0d m%0d l%0d"},
                   exp_r.row, exp_r.col, $signed(exp_r.gh), $signed(exp_r.gv), exp_r.mag,
                   exp_r.last, got.row, got.col, $signed(got.gh), $signed(got.gv), got.mag,
                   got.last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [12:0] cfg_data_i = '0;
  logic        calm = 1'b0;

  sobel_tracker tracker = new();

  sobel_edge_stream dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // stretches with no idling on either side
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) calm <= ~calm;
  end

  task automatic send_pixel(logic [7:0] px, logic fs);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= px;
    s_axis_tuser <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_pixel(px, fs);
  endtask

  task automatic write_reg(logic idx, logic [12:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (tracker.edge_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_size(logic [12:0] w, logic [12:0] h);
    drain();
    write_reg(CfgIdxWidth, w);
    write_reg(CfgIdxHeight, h);
  endtask

  task automatic random_frame(int n);
    logic [7:0] px;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: px = 8'd0;
        1: px = 8'd255;
        default: px = 8'($urandom_range(0, 255));
      endcase
      send_pixel(px, (i == 0) || ($urandom_range(0, 99) == 0));
    end
  endtask

  initial begin
    while (1) begin
      int stall;
      stall = calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_size(13'd3, 13'd3);
    // left column bright, then bottom row bright, then random
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 0) ? 8'd255 : 8'd0, i == 0);
    for (int i = 0; i < 9; i++) send_pixel((i >= 6) ? 8'd255 : 8'd0, i == 0);
    for (int i = 0; i < 9; i++) send_pixel(8'($urandom_range(0, 255)), i == 4);
    set_size(13'd0, 13'd0);
    random_frame(120);
    set_size(13'h1fff, 13'd3);
    random_frame(60);
    set_size(13'd5, 13'h1fff);
    random_frame(200);
    set_size(13'd2, 13'd2);
    random_frame(60);
    for (int p = 0; p < 5; p++) begin
      set_size(13'($urandom_range(3, 24)), 13'($urandom_range(3, 12)));
      random_frame(210);
    end
    drain();
    if (tracker.mismatches == 0 && tracker.edge_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/sobel_pkg.sv
rtl/core/sobel_ctrl.sv
rtl/core/sobel_dp.sv
rtl/core/sobel_edge_stream.sv
bench/tb_sobel_edge_stream.sv
